// ----- src/emaf_pkg.sv -----
package emaf_pkg;

  localparam int MODE_W     = 2;
  localparam int ALPHA_W    = 17;
  localparam int LEN_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int OUT_W      = 24;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'h10000;
  localparam logic [LEN_W-1:0]   LEN_RESET   = 7'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PASS = 2'd0,
    MODE_EMA  = 2'd1,
    MODE_AVG  = 2'd2,
    MODE_ZERO = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_ALPHA  = 2'd1,
    CFG_WINDOW = 2'd2
  } cfg_idx_t;

  // Effective configuration seen by the filter
  typedef struct packed {
    mode_t              mode;
    logic [ALPHA_W-1:0] alpha;
    logic [LEN_W-1:0]   len;
    logic               written;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic prime;
    logic pass;
    logic zero;
    logic ma_read;
    logic ma_update;
    logic div_init;
    logic div_step;
    logic div_end;
    logic mul_init;
    logic mul_step;
    logic mul_end;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic  prime_now;
    mode_t mode;
  } dp_sts_t;

endpackage

// ----- src/emaf_ifs.sv -----
interface emaf_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface emaf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [emaf_pkg::OUT_W-1:0]    filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

interface emaf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [emaf_pkg::CFG_IDX_W-1:0]      index;
  logic [emaf_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/emaf_cfg.sv -----
module emaf_cfg #(
  parameter int MAX_WINDOW = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  emaf_cfg_if.sink        cfg_if,
  output emaf_pkg::cfg_t  cfg_o
);

  emaf_pkg::mode_t                  mode_r, mode_nxt;
  logic [emaf_pkg::ALPHA_W-1:0]     alpha_r, alpha_nxt;
  logic [emaf_pkg::LEN_W-1:0]       wlen_r, wlen_nxt;
  logic                             hit;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    mode_nxt  = mode_r;
    alpha_nxt = alpha_r;
    wlen_nxt  = wlen_r;
    hit       = 1'b0;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        emaf_pkg::CFG_MODE: begin
          mode_nxt = emaf_pkg::mode_t'(cfg_if.data[emaf_pkg::MODE_W-1:0]);
          hit      = 1'b1;
        end
        emaf_pkg::CFG_ALPHA: begin
          alpha_nxt = cfg_if.data[emaf_pkg::ALPHA_W-1:0];
          hit       = 1'b1;
        end
        emaf_pkg::CFG_WINDOW: begin
          wlen_nxt = cfg_if.data[emaf_pkg::LEN_W-1:0];
          hit      = 1'b1;
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= emaf_pkg::MODE_PASS;
      alpha_r <= emaf_pkg::ALPHA_RESET;
      wlen_r  <= emaf_pkg::LEN_RESET;
    end else begin
      mode_r  <= mode_nxt;
      alpha_r <= alpha_nxt;
      wlen_r  <= wlen_nxt;
    end
  end

  // Clamp alpha to 1.0 and the window to 1..MAX_WINDOW
  always_comb begin
    cfg_o.mode    = mode_r;
    cfg_o.alpha   = (alpha_r > emaf_pkg::ALPHA_ONE) ? emaf_pkg::ALPHA_ONE : alpha_r;
    if (wlen_r == '0) begin
      cfg_o.len = emaf_pkg::LEN_W'(1);
    end else if (32'(wlen_r) > 32'(MAX_WINDOW)) begin
      cfg_o.len = emaf_pkg::LEN_W'(MAX_WINDOW);
    end else begin
      cfg_o.len = wlen_r;
    end
    cfg_o.written = hit;
  end

endmodule

// ----- src/emaf_ctrl.sv -----
module emaf_ctrl #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  emaf_pkg::dp_sts_t   sts,
  output emaf_pkg::dp_cmd_t   cmd
);

  localparam int DIV_ITERS = SAMPLE_BITS + emaf_pkg::LEN_W + 8;
  localparam int MUL_ITERS = emaf_pkg::ALPHA_W;
  localparam int CNT_W     = $clog2(DIV_ITERS);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_EVAL     = 9'b000000010,
    S_MA_UPD   = 9'b000000100,
    S_DIV_INIT = 9'b000001000,
    S_DIV      = 9'b000010000,
    S_DIV_END  = 9'b000100000,
    S_MUL      = 9'b001000000,
    S_MUL_END  = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.prime_now) begin
          cmd.prime = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          unique case (sts.mode)
            emaf_pkg::MODE_PASS: begin
              cmd.pass  = 1'b1;
              state_nxt = S_FINISH;
            end
            emaf_pkg::MODE_ZERO: begin
              cmd.zero  = 1'b1;
              state_nxt = S_FINISH;
            end
            emaf_pkg::MODE_EMA: begin
              cmd.mul_init = 1'b1;
              cnt_nxt      = CNT_W'(MUL_ITERS - 1);
              state_nxt    = S_MUL;
            end
            emaf_pkg::MODE_AVG: begin
              cmd.ma_read = 1'b1;
              state_nxt   = S_MA_UPD;
            end
          endcase
        end
      end
      S_MA_UPD: begin
        cmd.ma_update = 1'b1;
        state_nxt     = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = CNT_W'(DIV_ITERS - 1);
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DIV_END;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_DIV_END: begin
        cmd.div_end = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_MUL_END;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_MUL_END: begin
        cmd.mul_end = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        // hold the result until the output slot is free
        if (!out_valid_r || out_ready) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- src/emaf_dp.sv -----
module emaf_dp #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  emaf_pkg::cfg_t                     cfg,
  input  emaf_pkg::dp_cmd_t                  cmd,
  output emaf_pkg::dp_sts_t                  sts,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample,
  input  logic                               in_restart,
  output logic signed [emaf_pkg::OUT_W-1:0]  out_filtered
);

  localparam int LEN_W = emaf_pkg::LEN_W;
  localparam int OUT_W = emaf_pkg::OUT_W;
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W = SAMPLE_BITS + LEN_W;
  localparam int NUM_W = SUM_W + 8;
  localparam int SV_W  = SAMPLE_BITS + 16;
  localparam int P_W   = SV_W + 19;
  localparam int XW_W  = SAMPLE_BITS + OUT_W;

  logic signed [SAMPLE_BITS-1:0]  x_r;
  logic                           restart_r;
  logic                           prime_pending_r;
  logic signed [SAMPLE_BITS-1:0]  fill_r;
  logic signed [SUM_W-1:0]        sum_r;
  logic signed [SV_W-1:0]         sv_r;
  logic [IDX_W-1:0]               newest_r;
  logic [IDX_W-1:0]               next_r;
  logic [LEN_W-1:0]               rewritten_r;
  logic signed [SAMPLE_BITS-1:0]  rd_r;
  logic signed [SAMPLE_BITS-1:0]  store [MAX_WINDOW];

  logic [LEN_W-1:0]               rem_r;
  logic [NUM_W-1:0]               numq_r;
  logic                           neg_r;

  logic signed [P_W-1:0]          acc_r;
  logic signed [P_W-1:0]          d_r;
  logic [emaf_pkg::ALPHA_W-1:0]   a_r;

  logic signed [OUT_W-1:0]        res_r;
  logic signed [OUT_W-1:0]        out_r;

  // combinational helpers
  logic [IDX_W-1:0]               nxt_idx;
  logic signed [XW_W-1:0]         x_wide;
  logic signed [OUT_W-1:0]        x_res;
  logic signed [SUM_W-1:0]        prime_sum;
  logic signed [SAMPLE_BITS-1:0]  old_v;
  logic signed [SUM_W-1:0]        sum_nxt;
  logic signed [NUM_W-1:0]        num;
  logic [LEN_W:0]                 trial;
  logic [LEN_W:0]                 trial_diff;
  logic                           trial_ge;
  logic signed [NUM_W:0]          quot;
  logic signed [SV_W:0]           ema_diff;
  logic signed [SV_W-1:0]         ema_sv;
  logic signed [SV_W+8:0]         ema_rnd;

  assign sts.prime_now = prime_pending_r || restart_r;
  assign sts.mode      = cfg.mode;
  assign out_filtered  = out_r;

  assign nxt_idx = (32'(newest_r) + 32'd1 == 32'(cfg.len)) ? '0 : newest_r + IDX_W'(1);

  assign x_wide    = XW_W'(x_r);
  assign x_res     = {x_wide[OUT_W-9:0], 8'h00};
  assign prime_sum = SUM_W'(x_r) * $signed(SUM_W'({1'b0, cfg.len}));

  // entries not rewritten since the last prime read as the fill value
  assign old_v   = (32'(next_r) < 32'(rewritten_r)) ? rd_r : fill_r;
  assign sum_nxt = sum_r + SUM_W'(x_r) - SUM_W'(old_v);
  assign num     = $signed({sum_r, 8'h00});

  assign trial      = {rem_r, numq_r[NUM_W-1]};
  assign trial_ge   = (trial >= {1'b0, cfg.len});
  assign trial_diff = trial - {1'b0, cfg.len};
  assign quot       = neg_r ? -$signed({1'b0, numq_r}) : $signed({1'b0, numq_r});

  assign ema_diff = $signed({x_r, 16'h0000}) - sv_r;
  assign ema_sv   = acc_r[SV_W+15:16];
  assign ema_rnd  = (SV_W+9)'(ema_sv) + (SV_W+9)'(128);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_pending_r <= 1'b1;
      fill_r          <= '0;
      sum_r           <= '0;
      sv_r            <= '0;
      newest_r        <= '0;
      rewritten_r     <= '0;
    end else begin
      if (cfg.written) begin
        prime_pending_r <= 1'b1;
      end
      if (cmd.prime) begin
        prime_pending_r <= 1'b0;
        fill_r          <= x_r;
        sum_r           <= prime_sum;
        sv_r            <= {x_r, 16'h0000};
        newest_r        <= IDX_W'(32'(cfg.len) - 32'd1);
        rewritten_r     <= '0;
      end
      if (cmd.pass) begin
        sv_r <= {x_r, 16'h0000};
      end
      if (cmd.zero) begin
        sv_r <= '0;
      end
      if (cmd.ma_update) begin
        sum_r    <= sum_nxt;
        newest_r <= next_r;
        if (32'(rewritten_r) < 32'(cfg.len)) begin
          rewritten_r <= rewritten_r + LEN_W'(1);
        end
      end
      if (cmd.div_end) begin
        sv_r <= {quot[SV_W-9:0], 8'h00};
      end
      if (cmd.mul_end) begin
        sv_r <= ema_sv;
      end
    end
  end

  // ring store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.ma_update) begin
      store[next_r] <= x_r;
    end
    if (cmd.ma_read) begin
      rd_r <= store[nxt_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r       <= in_sample;
      restart_r <= in_restart;
    end
    if (cmd.ma_read) begin
      next_r <= nxt_idx;
    end

    // restoring divide of |sum*256| by the window length
    if (cmd.div_init) begin
      neg_r  <= sum_r[SUM_W-1];
      numq_r <= sum_r[SUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem_r  <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= trial_ge ? trial_diff[LEN_W-1:0] : trial[LEN_W-1:0];
      numq_r <= {numq_r[NUM_W-2:0], trial_ge};
    end

    // shift-add multiply, alpha LSB first; seed with y*65536 plus half an LSB
    if (cmd.mul_init) begin
      acc_r <= P_W'($signed({sv_r, 16'h8000}));
      d_r   <= P_W'(ema_diff);
      a_r   <= cfg.alpha;
    end
    if (cmd.mul_step) begin
      if (a_r[0]) begin
        acc_r <= acc_r + d_r;
      end
      d_r <= d_r <<< 1;
      a_r <= a_r >> 1;
    end

    if (cmd.prime || cmd.pass) begin
      res_r <= x_res;
    end
    if (cmd.zero) begin
      res_r <= '0;
    end
    if (cmd.div_end) begin
      res_r <= quot[OUT_W-1:0];
    end
    if (cmd.mul_end) begin
      res_r <= ema_rnd[OUT_W+7:8];
    end
    if (cmd.publish) begin
      out_r <= res_r;
    end
  end

endmodule

// ----- src/ema_or_moving_average_filter.sv -----
// Signed-sample smoothing filter with four modes: pass-through, first-order
// low-pass (y = a*x + (1-a)*y, alpha in Q1.16), moving average over 1 to
// MAX_WINDOW samples, and constant zero; each accepted word yields exactly
// one Q16.8 result word. Reset, any write to a defined config register, or a
// word with restart set primes the filter: that word comes out unchanged and
// seeds both the low-pass state and the whole averaging window. Words are
// handled one at a time. The moving average runs a restoring divider that
// retires one quotient bit per cycle; the low-pass runs a 17-step shift-add
// multiplier; pass-through, zero and priming words need neither.
// A finished word waits in the output register while the next word is taken.
// The config port is always ready; write it only while the filter is idle.
// The window ring needs no clearing pass after reset.
module ema_or_moving_average_filter #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  emaf_in_if.sink      in_if,
  emaf_out_if.source   out_if,
  emaf_cfg_if.sink     cfg_if
);

  emaf_pkg::cfg_t     cfg;
  emaf_pkg::dp_cmd_t  cmd;
  emaf_pkg::dp_sts_t  sts;

  // config registers, clamped to their legal ranges
  emaf_cfg #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg_o  (cfg)
  );

  // sequencer: picks the mode path, counts divider and multiplier steps,
  // and owns the output word's valid flag
  emaf_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // filter state, window ring, serial divider and multiplier
  emaf_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .in_sample    (in_if.sample),
    .in_restart   (in_if.restart),
    .out_filtered (out_if.filtered)
  );

endmodule

// ----- sim/emaf_result_checker.sv -----
`timescale 1ns / 1ps

module emaf_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  emaf_in_if          in_ch,
  emaf_out_if         out_ch,
  emaf_cfg_if         cfg_ch,
  output int unsigned fail_count,
  output int unsigned pending
);

  localparam int WINDOW_MAX = 64;
  localparam int SAMPLE_W   = 16;

  emaf_pkg::mode_t                       mode_r;
  logic [emaf_pkg::ALPHA_W-1:0]          alpha_r;
  logic [emaf_pkg::LEN_W-1:0]            len_r;

  logic signed [SAMPLE_W-1:0]  ring [WINDOW_MAX];
  logic [5:0]                  newest;
  logic signed [22:0]          wsum;
  logic signed [31:0]          smooth;
  logic                        prime;
  logic signed [SAMPLE_W-1:0]  fill;
  logic [6:0]                  rewritten;

  logic [emaf_pkg::OUT_W-1:0]  expected_filtered [$];
  int unsigned                 nfail = 0;

  // Work out the filtered word for one accepted sample and advance the state.
  task automatic advance_filter(input logic signed [SAMPLE_W-1:0] x, input logic rs,
                                output logic [emaf_pkg::OUT_W-1:0] y);
    longint xs, len, a, acc, s, res, old;
    int     nx;
    xs  = x;
    len = (len_r == 0) ? 1 : (len_r > WINDOW_MAX) ? WINDOW_MAX : len_r;
    if (rs) prime = 1'b1;
    if (prime) begin
      prime     = 1'b0;
      fill      = x;
      wsum      = 23'(xs * len);
      rewritten = '0;
      newest    = 6'(len - 1);
      smooth    = 32'(xs * 65536);
      res       = xs * 256;
    end else begin
      case (mode_r)
        emaf_pkg::MODE_EMA: begin
          a      = (alpha_r > emaf_pkg::ALPHA_ONE) ? 65536 : alpha_r;
          acc    = a * (xs * 65536) + (65536 - a) * longint'(smooth);
          s      = (acc + 32768) >>> 16;
          smooth = 32'(s);
          res    = (s + 128) >>> 8;
        end
        emaf_pkg::MODE_AVG: begin
          nx  = (int'(newest) + 1) % int'(len);
          old = (nx < rewritten) ? longint'(ring[nx]) : longint'(fill);
          wsum = 23'(longint'(wsum) + xs - old);
          ring[nx] = x;
          if (rewritten < len) rewritten = rewritten + 1'b1;
          newest = 6'(nx);
          res    = (longint'(wsum) * 256) / len;
          smooth = 32'(res * 256);
        end
        emaf_pkg::MODE_PASS: begin
          res    = xs * 256;
          smooth = 32'(xs * 65536);
        end
        default: begin
          res    = 0;
          smooth = '0;
        end
      endcase
    end
    y = emaf_pkg::OUT_W'(res);
  endtask

  function automatic void report(input string what, input logic [emaf_pkg::OUT_W-1:0] want,
                                 input logic [emaf_pkg::OUT_W-1:0] got);
    if (nfail < 10)
      $display("%0t: %s: expected %h (%0d), got %h (%0d)", $realtime, what,
               want, $signed(want), got, $signed(got));
    nfail++;
  endfunction

  always @(posedge clk) begin
    logic [emaf_pkg::OUT_W-1:0] want;
    if (!rst_n) begin
      mode_r    = emaf_pkg::MODE_PASS;
      alpha_r   = emaf_pkg::ALPHA_RESET;
      len_r     = emaf_pkg::LEN_RESET;
      foreach (ring[i]) ring[i] = '0;
      newest    = '0;
      wsum      = '0;
      smooth    = '0;
      prime     = 1'b1;
      fill      = '0;
      rewritten = '0;
      expected_filtered.delete();
    end else begin
      // Retire the output word first so a stray word never matches a fresh push.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_filtered.size() == 0) begin
          report("unexpected output word", 'x, out_ch.filtered);
        end else begin
          want = expected_filtered.pop_front();
          if (want !== out_ch.filtered) report("filtered mismatch", want, out_ch.filtered);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          emaf_pkg::CFG_MODE: begin
            mode_r = emaf_pkg::mode_t'(cfg_ch.data[emaf_pkg::MODE_W-1:0]);
            prime  = 1'b1;
          end
          emaf_pkg::CFG_ALPHA: begin
            alpha_r = cfg_ch.data[emaf_pkg::ALPHA_W-1:0];
            prime   = 1'b1;
          end
          emaf_pkg::CFG_WINDOW: begin
            len_r = cfg_ch.data[emaf_pkg::LEN_W-1:0];
            prime = 1'b1;
          end
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        advance_filter(in_ch.sample, in_ch.restart, want);
        expected_filtered.push_back(want);
      end
    end
    pending    <= expected_filtered.size();
    fail_count <= nfail;
  end

endmodule

// ----- sim/tb_ema_or_moving_average_filter.sv -----
`timescale 1ns / 1ps

module tb_ema_or_moving_average_filter;

  // Index with no register behind it: the write is dropped and must not prime.
  localparam logic [emaf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic        clk;
  logic        rst_n;
  int unsigned fails;
  int unsigned waiting;
  int unsigned sent = 0;
  bit          steady = 1'b0;

  emaf_in_if #(.SAMPLE_BITS(16)) in_ch ();
  emaf_out_if                    out_ch ();
  emaf_cfg_if                    cfg_ch ();

  ema_or_moving_average_filter #(
    .MAX_WINDOW (64),
    .SAMPLE_BITS(16)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  emaf_result_checker i_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .fail_count(fails),
    .pending   (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case a word never comes out or the handshake hangs.
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Idle length: mostly none or short, now and then a long hold.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Result side: stall ready in random stretches; no new stall starts while a steady phase runs.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  // Hold valid high until the word is taken; valid stays up for a back-to-back word.
  task automatic send_word(input logic signed [15:0] s, input logic r);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= s;
    in_ch.restart <= r;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // Drop valid and wait until every predicted word has come out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  // Caller lowers cfg valid once the whole series is done.
  task automatic write_reg(input logic [emaf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [emaf_pkg::CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Write the selected registers with the filter idle; unused data bits get noise.
  task automatic write_setting(input emaf_pkg::mode_t m,
                               input logic [emaf_pkg::ALPHA_W-1:0] a,
                               input logic [emaf_pkg::LEN_W-1:0] w, input logic [2:0] pick,
                               input bit spare);
    logic [emaf_pkg::CFG_DATA_W-1:0] d;
    wait_drained();
    if (pick[0]) begin
      d = emaf_pkg::CFG_DATA_W'($urandom);
      d[emaf_pkg::MODE_W-1:0] = m;
      write_reg(emaf_pkg::CFG_MODE, d);
    end
    if (pick[1]) write_reg(emaf_pkg::CFG_ALPHA, a);
    if (spare) write_reg(CFG_SPARE, emaf_pkg::CFG_DATA_W'($urandom));
    if (pick[2]) begin
      d = emaf_pkg::CFG_DATA_W'($urandom);
      d[emaf_pkg::LEN_W-1:0] = w;
      write_reg(emaf_pkg::CFG_WINDOW, d);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    emaf_pkg::mode_t                 m;
    logic [emaf_pkg::ALPHA_W-1:0]    a;
    logic [emaf_pkg::LEN_W-1:0]      w;
    logic signed [15:0]              s;
    int                              eff;
    int                              n;

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.sample   <= '0;
    in_ch.restart  <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= '0;
    cfg_ch.data    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: the first word primes, then pass-through; restart mid-run.
    send_word(16'sd32767, 1'b0);
    send_word(-16'sd32768, 1'b0);
    send_word(-16'sd1, 1'b0);
    send_word(16'sd12345, 1'b1);

    // Low-pass with zero weight: output sticks at the primed value.
    write_setting(emaf_pkg::MODE_EMA, 17'd0, 7'd1, 3'b111, 1'b0);
    send_word(16'sd1000, 1'b0);
    send_word(-16'sd32768, 1'b0);
    send_word(16'sd32767, 1'b0);

    // Weight above one is clamped to one.
    write_setting(emaf_pkg::MODE_EMA, 17'h1FFFF, 7'd1, 3'b010, 1'b0);
    send_word(-16'sd32768, 1'b0);
    send_word(16'sd32767, 1'b0);

    // Half weight, with a restart in the middle of the run.
    write_setting(emaf_pkg::MODE_EMA, 17'd32768, 7'd1, 3'b010, 1'b0);
    send_word(16'sd100, 1'b0);
    send_word(16'sd32767, 1'b0);
    send_word(-16'sd5, 1'b1);
    send_word(16'sd7, 1'b0);

    // A write to the spare index alone must leave the low-pass state alone.
    write_setting(emaf_pkg::MODE_EMA, 17'd0, 7'd0, 3'b000, 1'b1);
    send_word(16'sd3, 1'b0);

    // Window length zero acts as one.
    write_setting(emaf_pkg::MODE_AVG, 17'd0, 7'd0, 3'b101, 1'b0);
    send_word(16'sd5, 1'b0);
    send_word(-16'sd3, 1'b0);

    // Oversized window clamps to the full ring; extreme sums.
    write_setting(emaf_pkg::MODE_AVG, 17'd0, 7'd127, 3'b100, 1'b0);
    send_word(16'sd32767, 1'b0);
    send_word(-16'sd32768, 1'b0);

    // Short window wraps; negative sums truncate toward zero.
    write_setting(emaf_pkg::MODE_AVG, 17'd0, 7'd3, 3'b100, 1'b0);
    send_word(16'sd7, 1'b0);
    send_word(16'sd1, 1'b0);
    send_word(-16'sd1, 1'b0);
    send_word(16'sd2, 1'b0);
    send_word(-16'sd32768, 1'b0);

    write_setting(emaf_pkg::MODE_ZERO, 17'd0, 7'd3, 3'b001, 1'b0);
    send_word(16'sd42, 1'b0);
    send_word(-16'sd42, 1'b0);

    // Random phases: new setting, then a run of samples long enough to wrap the window.
    while (sent < 550) begin
      m = emaf_pkg::mode_t'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
        0:       a = 17'd0;
        1:       a = emaf_pkg::ALPHA_ONE;
        2:       a = 17'($urandom_range(65537, 131071));
        3:       a = 17'($urandom_range(1, 255));
        default: a = 17'($urandom_range(0, 65536));
      endcase
      case ($urandom_range(0, 7))
        0:       w = 7'd0;
        1:       w = 7'd1;
        2:       w = 7'd64;
        3:       w = 7'($urandom_range(65, 127));
        4:       w = 7'($urandom_range(9, 63));
        default: w = 7'($urandom_range(2, 8));
      endcase
      if ($urandom_range(0, 4) == 0)
        write_setting(m, a, w, 3'($urandom_range(0, 7)), $urandom_range(0, 3) == 0);
      else
        write_setting(m, a, w, 3'b111, $urandom_range(0, 3) == 0);

      steady = ($urandom_range(0, 9) == 0);
      eff = (w == 0) ? 1 : (w > 64) ? 64 : int'(w);
      if (m == emaf_pkg::MODE_AVG && eff >= 8) n = eff + $urandom_range(4, eff + 8);
      else n = $urandom_range(8, 40);

      repeat (n) begin
        case ($urandom_range(0, 19))
          0:       s = -16'sd32768;
          1:       s = 16'sd32767;
          2:       s = 16'sd0;
          3:       s = -16'sd1;
          4, 5:    s = 16'($signed($urandom_range(0, 200)) - 100);
          default: s = 16'($urandom);
        endcase
        send_word(s, $urandom_range(0, 99) < 5);
        // Hold off now and then until the filter has drained.
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
    end

    steady = 1'b0;
    wait_drained();
    repeat (60) @(posedge clk);
    if (fails == 0 && waiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
